FILE: src/udf_pkg.sv
// ----------------------------------------------------------------------------
// udf_pkg
// Shared types and constants for the deduplicating id queue.
// ----------------------------------------------------------------------------
`default_nettype none

package udf_pkg;

   // id width and the "no entry" sentinel
   localparam int unsigned ID_W = 8;
   localparam logic [ID_W-1:0] NONE_ID = 8'hFF;

   // item modes
   localparam logic [1:0] MODE_MARK   = 2'd0;
   localparam logic [1:0] MODE_POP    = 2'd1;
   localparam logic [1:0] MODE_RESYNC = 2'd2;

   // link sweep status, sweep unit to controller
   typedef struct packed {
      logic active;   // a link write goes out this cycle
      logic last;     // this is the final entry of the sweep
   } sweep_status_type;

endpackage

`default_nettype wire

FILE: src/udf_ram.sv
// ----------------------------------------------------------------------------
// udf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module udf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 255
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: src/udf_sweep.sv
// ----------------------------------------------------------------------------
// udf_sweep
// Walks every link entry once, writing i+1 for i+1 < count, else NONE.
// Runs with count 0 right after reset to clear the table.
// ----------------------------------------------------------------------------
`default_nettype none

module udf_sweep #(
   parameter int unsigned MAX_ENTRIES = 255
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      go,
   input  wire logic [udf_pkg::ID_W-1:0]  count,
   output udf_pkg::sweep_status_type      status,
   output logic      [udf_pkg::ID_W-1:0]  wr_id,
   output logic      [udf_pkg::ID_W-1:0]  wr_link
);

   localparam int unsigned AW = $clog2(MAX_ENTRIES);
   localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ENTRIES - 1);

   logic                       active_ff, active_in;
   logic [AW-1:0]              idx_ff, idx_in;
   logic [udf_pkg::ID_W-1:0]   count_ff, count_in;
   logic [udf_pkg::ID_W:0]     idx_plus;
   logic                       last;

   // link value for the current entry
   assign idx_plus = (udf_pkg::ID_W+1)'(idx_ff) + 1'b1;
   assign last     = (idx_ff == LAST_IDX);
   assign wr_id    = udf_pkg::ID_W'(idx_ff);
   assign wr_link  = (idx_plus < {1'b0, count_ff}) ? idx_plus[udf_pkg::ID_W-1:0]
                                                   : udf_pkg::NONE_ID;

   assign status.active = active_ff;
   assign status.last   = active_ff & last;

   // sequencing
   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      if (active_ff) begin
         idx_in = idx_ff + 1'b1;
         if (last) begin
            active_in = 1'b0;
            idx_in    = '0;
         end
      end else if (go) begin
         active_in = 1'b1;
         idx_in    = '0;
         count_in  = count;
      end
   end

   // clear pass starts from reset
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         idx_ff    <= '0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/unique_dirty_fifo.sv
// ----------------------------------------------------------------------------
// unique_dirty_fifo
// FIFO of entry ids holding each id at most once, kept as a linked list.
// ----------------------------------------------------------------------------
// A mark or pop goes from start to rsp_strobe through the link table read,
// then the step that updates head/tail and writes the link back; busy is
// low again in the cycle the response is shown, so a new item can go in then.
// A resync rewrites every link entry, one per cycle, and answers after the
// last entry is written; mode 3 answers like a mark that does nothing.
// After reset the block runs the sweep to clear the link table, with
// busy high; csr writes are taken at any time. Results show for exactly one
// cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module unique_dirty_fifo #(
   parameter int unsigned MAX_ENTRIES = 255
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // item channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_mode,
   input  wire logic [7:0]  req_entry_id,
   // result channel
   output logic             rsp_strobe,
   output logic             rsp_popped_valid,
   output logic [7:0]       rsp_popped_id,
   output logic             rsp_was_added,
   output logic             rsp_queue_empty,
   // entry count register
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data
);

   localparam int unsigned AW = $clog2(MAX_ENTRIES);
   localparam logic [7:0]  MAX_ID8 = 8'(MAX_ENTRIES);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_SWEEP = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [7:0]  entry_count_ff;
   logic [7:0]  head_ff, head_in;
   logic [7:0]  tail_ff, tail_in;
   logic [1:0]  mode_ff;
   logic [7:0]  id_ff;
   logic        mark_ok_ff, mark_ok_in;
   logic        sweep_rsp_ff, sweep_rsp_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   logic        rsp_pv_ff, rsp_pv_in;
   logic [7:0]  rsp_pid_ff, rsp_pid_in;
   logic        rsp_added_ff, rsp_added_in;
   logic        rsp_empty_ff, rsp_empty_in;

   logic [7:0]  eff_count;
   logic        accept;
   logic        sweep_go;

   udf_pkg::sweep_status_type sweep_st;
   logic [7:0]  sweep_id, sweep_link;

   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic          exec_wr_en;
   logic [7:0]    exec_wr_id;
   logic [7:0]    exec_wr_data;
   logic          queued;

   // handshake
   assign busy      = (state_ff != S_IDLE);
   assign accept    = start & ~busy;
   assign csr_ready = 1'b1;
   assign eff_count = (entry_count_ff > MAX_ID8) ? MAX_ID8 : entry_count_ff;
   assign mark_ok_in = (req_entry_id != udf_pkg::NONE_ID) && (req_entry_id < eff_count);
   assign sweep_go  = accept && (req_mode == udf_pkg::MODE_RESYNC);

   // link table read on accept: the marked id or the current head
   assign ram_rd_en   = accept;
   assign ram_rd_addr = (req_mode == udf_pkg::MODE_POP) ? head_ff[AW-1:0]
                                                        : req_entry_id[AW-1:0];

   // write port shared by the sweep and the execute step
   assign ram_wr_en   = sweep_st.active | exec_wr_en;
   assign ram_wr_addr = sweep_st.active ? sweep_id[AW-1:0] : exec_wr_id[AW-1:0];
   assign ram_wr_data = sweep_st.active ? sweep_link : exec_wr_data;

   udf_ram #(
      .WIDTH (8),
      .DEPTH (MAX_ENTRIES)
   ) u_links (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   udf_sweep #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_sweep (
      .clock   (clock),
      .reset   (reset),
      .go      (sweep_go),
      .count   (eff_count),
      .status  (sweep_st),
      .wr_id   (sweep_id),
      .wr_link (sweep_link)
   );

   assign queued = (tail_ff == id_ff) || (ram_rd_data != udf_pkg::NONE_ID);

   // control and execute step
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      sweep_rsp_in  = sweep_rsp_ff;
      exec_wr_en    = 1'b0;
      exec_wr_id    = tail_ff;
      exec_wr_data  = id_ff;
      rsp_strobe_in = 1'b0;
      rsp_pv_in     = 1'b0;
      rsp_pid_in    = '0;
      rsp_added_in  = 1'b0;
      rsp_empty_in  = (head_ff == udf_pkg::NONE_ID);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_mode == udf_pkg::MODE_RESYNC) begin
                  state_in     = S_SWEEP;
                  sweep_rsp_in = 1'b1;
                  if (eff_count == 8'd0) begin
                     head_in = udf_pkg::NONE_ID;
                     tail_in = udf_pkg::NONE_ID;
                  end else begin
                     head_in = 8'd0;
                     tail_in = eff_count - 8'd1;
                  end
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            if (mode_ff == udf_pkg::MODE_MARK) begin
               if (mark_ok_ff && !queued) begin
                  if (tail_ff != udf_pkg::NONE_ID) begin
                     exec_wr_en = 1'b1;
                  end else begin
                     head_in = id_ff;
                  end
                  tail_in      = id_ff;
                  rsp_added_in = 1'b1;
               end
            end else if (mode_ff == udf_pkg::MODE_POP) begin
               if (head_ff != udf_pkg::NONE_ID) begin
                  rsp_pv_in    = 1'b1;
                  rsp_pid_in   = head_ff;
                  head_in      = ram_rd_data;
                  exec_wr_en   = 1'b1;
                  exec_wr_id   = head_ff;
                  exec_wr_data = udf_pkg::NONE_ID;
                  if (ram_rd_data == udf_pkg::NONE_ID) begin
                     tail_in = udf_pkg::NONE_ID;
                  end
               end
            end
            rsp_empty_in = (head_in == udf_pkg::NONE_ID);
         end
         S_SWEEP: begin
            if (sweep_st.last) begin
               state_in      = S_IDLE;
               sweep_rsp_in  = 1'b0;
               rsp_strobe_in = sweep_rsp_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_SWEEP;
         head_ff        <= udf_pkg::NONE_ID;
         tail_ff        <= udf_pkg::NONE_ID;
         entry_count_ff <= '0;
         sweep_rsp_ff   <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         sweep_rsp_ff  <= sweep_rsp_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            entry_count_ff <= csr_data;
         end
      end
   end

   // item capture and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req_mode;
         id_ff      <= req_entry_id;
         mark_ok_ff <= mark_ok_in;
      end
      rsp_pv_ff    <= rsp_pv_in;
      rsp_pid_ff   <= rsp_pid_in;
      rsp_added_ff <= rsp_added_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_popped_valid = rsp_pv_ff;
   assign rsp_popped_id    = rsp_pid_ff;
   assign rsp_was_added    = rsp_added_ff;
   assign rsp_queue_empty  = rsp_empty_ff;

   // checks
   a_exec_answers: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode != udf_pkg::MODE_RESYNC) |-> ##2 rsp_strobe)
      else $error("mark/pop transfer gave no response two cycles later");

   a_head_tail_pair: assert property (@(posedge clock) disable iff (reset)
      (head_ff == udf_pkg::NONE_ID) == (tail_ff == udf_pkg::NONE_ID))
      else $error("head and tail disagree on empty queue");

   a_sweep_busy: assert property (@(posedge clock) disable iff (reset)
      sweep_st.active |-> busy)
      else $error("link sweep running while idle");

   a_pop_not_add: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_popped_valid && rsp_was_added))
      else $error("response both popped and added");

endmodule

`default_nettype wire
